@@ rtl/aes_pkg.sv @@
package aes_pkg;

  localparam int unsigned ROUNDS     = 14;
  localparam int unsigned KEY_WORDS  = 8;
  localparam int unsigned SCHED_WORDS = 4 * (ROUNDS + 1);
  localparam int unsigned RK_AW      = 6;
  localparam int unsigned CFG_AW     = 2;

  localparam logic [CFG_AW-1:0] REG_KEY_0 = 2'd0;
  localparam logic [CFG_AW-1:0] REG_KEY_1 = 2'd1;
  localparam logic [CFG_AW-1:0] REG_KEY_2 = 2'd2;
  localparam logic [CFG_AW-1:0] REG_KEY_3 = 2'd3;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_key;   // copy key words 0..7 into schedule regs
    logic       exp_step;   // compute next schedule word
    logic       load_block; // latch block, add round-0 key
    logic       rnd_step;   // one round
    logic       last_rnd;   // final round: no MixColumns
    logic [3:0] rnd_idx;    // round key index being fetched
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic exp_done;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXP   = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_RND   = 5'b01000,
    ST_OUT   = 5'b10000
  } ctl_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

@@ rtl/aes_ram.sv @@
module aes_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/aes_ctrl.sv @@
module aes_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             key_wr,
  output logic             busy,
  output logic             out_valid,
  input  aes_pkg::dp_sts_t sts,
  output aes_pkg::dp_cmd_t cmd
);
  import aes_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       ready_r, ready_nxt;
  logic [3:0] rnd_r, rnd_nxt;

  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (ready_r) begin
            state_nxt      = ST_FETCH;
          end else begin
            cmd.load_key   = 1'b1;
            state_nxt      = ST_EXP;
          end
        end
      end
      ST_EXP: begin
        cmd.exp_step = 1'b1;
        if (sts.exp_done) begin
          ready_nxt = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // read round key 0 from RAM
        cmd.rnd_idx = 4'd0;
        rnd_nxt     = 4'd1;
        state_nxt   = ST_RND;
      end
      ST_RND: begin
        cmd.rnd_idx = rnd_r;
        if (rnd_r == 4'd1) begin
          cmd.load_block = 1'b1;
        end else begin
          cmd.rnd_step = 1'b1;
          cmd.last_rnd = (rnd_r == 4'(ROUNDS + 1));
        end
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'(ROUNDS + 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (key_wr) begin
      ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
endmodule

@@ rtl/aes_dp.sv @@
module aes_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  aes_pkg::dp_cmd_t   cmd,
  output aes_pkg::dp_sts_t   sts,
  input  logic [255:0]       key,
  input  aes_pkg::in_item_t  in_item,
  output aes_pkg::out_item_t out_item
);
  import aes_pkg::*;

  // Key expansion: 8-word sliding window, one word per cycle while exp_step is set.
  logic [31:0] win_r [KEY_WORDS];
  logic [31:0] win_nxt [KEY_WORDS];
  logic [5:0]  widx_r;   // index of next word to produce
  logic [7:0]  rcon_r;
  logic [31:0] tw, nw;
  logic [31:0] grp_r [3];  // words of current round key being gathered
  logic        rk_we;
  logic [3:0]  rk_waddr;
  logic [127:0] rk_wdata, rk_rdata;
  logic [127:0] st_r;
  logic [127:0] sb, sr, mc, rnd_out;

  always_comb begin
    tw = win_r[KEY_WORDS-1];
    if (widx_r[2:0] == 3'd0) begin
      tw = sbox_word({tw[23:0], tw[31:24]}) ^ {rcon_r, 24'h0};
    end else if (widx_r[2:0] == 3'd4) begin
      tw = sbox_word(tw);
    end
    nw = win_r[0] ^ tw;
    for (int i = 0; i < KEY_WORDS - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[KEY_WORDS-1] = nw;
  end

  // Words stream out in order: first the 8 key words from the window, then
  // each new word. Group by four into 128-bit RAM rows.
  logic [31:0] emit_w;
  logic [5:0]  emit_idx;
  logic        emit_v;
  logic [2:0]  pre_r;    // emits the 8 key words before expanding
  logic        pre_act_r;

  always_comb begin
    emit_v   = 1'b0;
    emit_w   = nw;
    emit_idx = widx_r;
    if (cmd.exp_step) begin
      if (pre_act_r) begin
        emit_v   = 1'b1;
        emit_w   = win_r[pre_r];
        emit_idx = {3'd0, pre_r};
      end else begin
        emit_v   = 1'b1;
      end
    end
    rk_we    = emit_v && (emit_idx[1:0] == 2'd3);
    rk_waddr = emit_idx[5:2];
    rk_wdata = {grp_r[0], grp_r[1], grp_r[2], emit_w};
  end

  assign sts.exp_done = cmd.exp_step && !pre_act_r && (widx_r == 6'(SCHED_WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_act_r <= 1'b0;
      pre_r     <= '0;
    end else if (cmd.load_key) begin
      pre_act_r <= 1'b1;
      pre_r     <= '0;
    end else if (cmd.exp_step && pre_act_r) begin
      pre_r <= pre_r + 3'd1;
      if (pre_r == 3'(KEY_WORDS - 1)) begin
        pre_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        win_r[i] <= key[255-32*i -: 32];
      end
      widx_r <= 6'(KEY_WORDS);
      rcon_r <= 8'h01;
    end else if (cmd.exp_step && !pre_act_r) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        win_r[i] <= win_nxt[i];
      end
      widx_r <= widx_r + 6'd1;
      if (widx_r[2:0] == 3'd0) begin
        rcon_r <= xtime(rcon_r);
      end
    end
    if (emit_v) begin
      case (emit_idx[1:0])
        2'd0: grp_r[0] <= emit_w;
        2'd1: grp_r[1] <= emit_w;
        2'd2: grp_r[2] <= emit_w;
        default: ;
      endcase
    end
  end

  aes_ram #(.WIDTH(128), .DEPTH(ROUNDS + 1)) u_rk (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (cmd.rnd_idx),
    .rdata (rk_rdata)
  );

  // One round. Byte n = st[127-8n -: 8]; s[4c+r].
  always_comb begin
    for (int n = 0; n < 16; n++) begin
      sb[127-8*n -: 8] = SBOX[st_r[127-8*n -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(4*c+r) -: 8] = sb[127-8*(4*((c+r)%4)+r) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = sr[127-32*c -: 8];
      a1 = sr[119-32*c -: 8];
      a2 = sr[111-32*c -: 8];
      a3 = sr[103-32*c -: 8];
      mc[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mc[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mc[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mc[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    rnd_out = (cmd.last_rnd ? sr : mc) ^ rk_rdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      st_r <= {in_item.plain_high, in_item.plain_low} ^ rk_rdata;
    end else if (cmd.rnd_step) begin
      st_r <= rnd_out;
    end
  end

  assign out_item.cipher_high = st_r[127:64];
  assign out_item.cipher_low  = st_r[63:0];
endmodule

@@ rtl/aes256_block_encrypt.sv @@
// AES-256 encrypt, one 128-bit block per start.
// With a fresh key schedule, a block passes through fetch, initial key add,
// 14 rounds and output; a new start is taken only once busy has dropped.
// After a key write, the next block first expands the key schedule.
// Reset (sync, active low) clears the key registers and marks keys stale.
// out_valid is a one-cycle strobe; the receiver cannot stall.
module aes256_block_encrypt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  aes_pkg::in_item_t   in_item,
  output logic                out_valid,
  output aes_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import aes_pkg::*;

  logic [63:0] key_r [4];
  logic        key_wr;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  in_item_t    in_r;

  // Only indices 0..3 are key words; higher writes are dropped.
  assign key_wr = cfg_we && !cfg_index[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else if (key_wr) begin
      case (cfg_index[CFG_AW-1:0])
        REG_KEY_0: key_r[0] <= cfg_wdata;
        REG_KEY_1: key_r[1] <= cfg_wdata;
        REG_KEY_2: key_r[2] <= cfg_wdata;
        REG_KEY_3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Block is held while the key schedule runs.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
  end

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .key_wr    (key_wr),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  aes_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .key      ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .in_item  (in_r),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exp_step && (cmd.rnd_step || cmd.load_block)))
    else $error("expansion overlaps rounds");
`endif
endmodule
